// ===== rtl/core/bba_pkg.sv =====
// Shared types, constants and helpers for the buddy block allocator.
// No dependencies; imported by bba_node_ram and buddy_block_allocator_top.
package bba_pkg;

    // Built tree: pool of 2^POOL_LOG2 bytes, smallest block 2^MIN_BLOCK_LOG2
    localparam int POOL_LOG2      = 20;
    localparam int MIN_BLOCK_LOG2 = 3;
    localparam int NODE_IDX_W     = POOL_LOG2 - MIN_BLOCK_LOG2 + 1;
    localparam int NODE_COUNT     = (1 << NODE_IDX_W) - 1;
    localparam int ADDR_W         = 48;
    localparam int SIZE_W         = POOL_LOG2 + 1;
    localparam int OFF_W          = POOL_LOG2;
    localparam int LG_W           = $clog2(POOL_LOG2 + 1);
    localparam int CFG_IDX_W      = 2;

    // Request kinds
    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDRESS   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_POOL_SIZE_LOG2 = CFG_IDX_W'(1);

    // Node marks held in the tree
    typedef enum logic [1:0] {
        NODE_FREE  = 2'd0,
        NODE_ALLOC = 2'd1,
        NODE_SPLIT = 2'd2,
        NODE_FULL  = 2'd3
    } node_st_t;

    // Tree walk sequencer
    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_EVAL,
        S_ASCEND,
        S_UP,
        S_DONE
    } walk_state_t;

    // Parent mark from its two children
    function automatic node_st_t merge_status(node_st_t a, node_st_t b);
        logic a_full;
        logic b_full;
        a_full = (a == NODE_ALLOC) || (a == NODE_FULL);
        b_full = (b == NODE_ALLOC) || (b == NODE_FULL);
        if (a_full && b_full) begin
            return NODE_FULL;
        end else if ((a != NODE_FREE) || (b != NODE_FREE)) begin
            return NODE_SPLIT;
        end else begin
            return NODE_FREE;
        end
    endfunction

endpackage

// ===== rtl/core/buddy_block_allocator_top.sv =====
// Buddy block allocator: a request walks the node tree held in bba_node_ram.
// Depends on bba_pkg and bba_node_ram.
//
// One request is handled at a time. Going down, each level passes through a
// memory read (S_FETCH) and then an evaluation (S_EVAL); splitting a free
// block goes on in S_EVAL alone, one level per step; climbing back to update
// parents passes through S_ASCEND then S_UP per level; each right-hand subtree
// probed after a failed left one adds an extra down/up trip. All of it is paced
// by the registered read of the node memory. A rejected oversized request goes
// straight to S_DONE without walking the tree. The root mark is a register, so
// neither reset nor a register write needs a pass over the memory. Writing
// either register empties the pool. A finished result waits in the output
// register while the next transfer is taken in.
module buddy_block_allocator_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [bba_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bba_pkg::ADDR_W-1:0]     cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_kind,
    input  logic [bba_pkg::SIZE_W-1:0]     s_request_size,
    input  logic [bba_pkg::ADDR_W-1:0]     s_free_address,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [bba_pkg::ADDR_W-1:0]     m_block_address,
    output logic                           m_ok,
    output logic [bba_pkg::SIZE_W-1:0]     m_allocated_total
);
    import bba_pkg::*;

    // Control and configuration registers
    walk_state_t             state_reg, state_next;
    node_st_t                root_reg, root_next;
    logic [SIZE_W-1:0]       total_reg, total_next;
    logic [ADDR_W-1:0]       base_reg, base_next;
    logic [LG_W-1:0]         plog_reg, plog_next;
    logic                    m_valid_reg, m_valid_next;

    // Walk registers
    logic [NODE_IDX_W-1:0]   idx_reg, idx_next;
    logic [LG_W-1:0]         lg_reg, lg_next;
    logic [OFF_W-1:0]        off_reg, off_next;
    node_st_t                cst_reg, cst_next;
    logic                    use_mem_reg, use_mem_next;
    logic                    got_reg, got_next;
    logic                    kind_reg, kind_next;
    logic [LG_W-1:0]         need_reg, need_next;
    logic [ADDR_W-1:0]       addr_reg, addr_next;
    logic [OFF_W-1:0]        where_reg, where_next;

    // Output payload
    logic [ADDR_W-1:0]       m_addr_reg, m_addr_next;
    logic                    m_ok_reg, m_ok_next;
    logic [SIZE_W-1:0]       m_total_reg, m_total_next;

    // Memory port
    logic                    ram_we, ram_re;
    logic [NODE_IDX_W-1:0]   ram_waddr, ram_raddr;
    logic [1:0]              ram_wdata, ram_rdata;

    // Decode
    logic [SIZE_W-1:0]       size_m1;
    logic [LG_W-1:0]         bit_len;
    logic [LG_W-1:0]         req_need;
    logic                    req_too_big;
    node_st_t                eval_st;
    logic [SIZE_W-1:0]       blk_size;
    logic [OFF_W-1:0]        half_off;
    logic [ADDR_W:0]         node_base;
    logic [ADDR_W:0]         split_point;
    logic                    go_left;
    logic                    addr_hit;
    logic [NODE_IDX_W-1:0]   left_idx, right_idx, parent_idx, sib_idx;
    logic                    is_alloc;
    logic                    ev_descend, ev_split, ev_take;
    logic                    at_root;
    logic                    try_right;
    logic                    out_free;
    logic [4:0]              cfg_lg;

    bba_node_ram u_node_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // Rounded block size of an incoming allocate, as log2
    always_comb begin
        size_m1 = s_request_size - SIZE_W'(1);
        bit_len = '0;
        for (int i = 0; i < SIZE_W; i++) begin
            if (size_m1[i]) begin
                bit_len = LG_W'(i + 1);
            end
        end
        if (s_request_size <= SIZE_W'(1 << MIN_BLOCK_LOG2)) begin
            req_need = LG_W'(MIN_BLOCK_LOG2);
        end else begin
            req_need = bit_len;
        end
        req_too_big = (s_kind == KIND_ALLOC) && (req_need > plog_reg);
    end

    // Current node decode
    assign eval_st     = use_mem_reg ? node_st_t'(ram_rdata) : cst_reg;
    assign blk_size    = SIZE_W'(1) << lg_reg;
    assign half_off    = OFF_W'(blk_size >> 1);
    assign node_base   = {1'b0, base_reg} + (ADDR_W + 1)'(off_reg);
    assign split_point = node_base + (ADDR_W + 1)'(half_off);
    assign go_left     = split_point > {1'b0, addr_reg};
    assign addr_hit    = node_base == {1'b0, addr_reg};
    assign left_idx    = {idx_reg[NODE_IDX_W-2:0], 1'b1};
    assign right_idx   = left_idx + NODE_IDX_W'(1);
    assign parent_idx  = (idx_reg - NODE_IDX_W'(1)) >> 1;
    assign sib_idx     = idx_reg[0] ? idx_reg + NODE_IDX_W'(1) : idx_reg - NODE_IDX_W'(1);
    assign is_alloc    = kind_reg == KIND_ALLOC;
    assign at_root     = idx_reg == '0;
    assign try_right   = is_alloc && !got_reg && idx_reg[0];
    assign out_free    = !m_valid_reg || m_ready;

    // What the walk does with the node under evaluation
    always_comb begin
        if (is_alloc) begin
            ev_descend = eval_st == NODE_SPLIT;
            ev_split   = (eval_st == NODE_FREE) && (lg_reg > need_reg);
            ev_take    = (eval_st == NODE_FREE) && (lg_reg == need_reg);
        end else begin
            ev_descend = (eval_st == NODE_SPLIT) || (eval_st == NODE_FULL);
            ev_split   = 1'b0;
            ev_take    = (eval_st == NODE_ALLOC) && addr_hit;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = req_too_big ? S_DONE : S_EVAL;
                end
            end
            S_FETCH: state_next = S_EVAL;
            S_EVAL: begin
                if (ev_descend) begin
                    state_next = S_FETCH;
                end else if (ev_split) begin
                    state_next = S_EVAL;
                end else begin
                    state_next = S_ASCEND;
                end
            end
            S_ASCEND: begin
                if (at_root) begin
                    state_next = S_DONE;
                end else if (try_right) begin
                    state_next = S_FETCH;
                end else begin
                    state_next = S_UP;
                end
            end
            S_UP: state_next = S_ASCEND;
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Datapath, memory port and outputs
    always_comb begin
        root_next    = root_reg;
        total_next   = total_reg;
        base_next    = base_reg;
        plog_next    = plog_reg;
        m_valid_next = m_valid_reg;
        idx_next     = idx_reg;
        lg_next      = lg_reg;
        off_next     = off_reg;
        cst_next     = cst_reg;
        use_mem_next = use_mem_reg;
        got_next     = got_reg;
        kind_next    = kind_reg;
        need_next    = need_reg;
        addr_next    = addr_reg;
        where_next   = where_reg;
        m_addr_next  = m_addr_reg;
        m_ok_next    = m_ok_reg;
        m_total_next = m_total_reg;
        ram_we       = 1'b0;
        ram_waddr    = idx_reg;
        ram_wdata    = cst_reg;
        ram_re       = 1'b0;
        ram_raddr    = idx_reg;
        cfg_lg       = cfg_wdata[4:0];

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    kind_next    = s_kind;
                    need_next    = req_need;
                    addr_next    = s_free_address;
                    idx_next     = '0;
                    lg_next      = plog_reg;
                    off_next     = '0;
                    cst_next     = root_reg;
                    use_mem_next = 1'b0;
                    got_next     = 1'b0;
                end
            end
            S_FETCH: begin
                ram_re       = 1'b1;
                ram_raddr    = idx_reg;
                use_mem_next = 1'b1;
            end
            S_EVAL: begin
                if (ev_descend) begin
                    lg_next = lg_reg - LG_W'(1);
                    if (is_alloc || go_left) begin
                        idx_next = left_idx;
                    end else begin
                        idx_next = right_idx;
                        off_next = off_reg + half_off;
                    end
                end else if (ev_split) begin
                    // upper half becomes a free leaf, lower half is walked next
                    ram_we       = 1'b1;
                    ram_waddr    = right_idx;
                    ram_wdata    = NODE_FREE;
                    idx_next     = left_idx;
                    lg_next      = lg_reg - LG_W'(1);
                    cst_next     = NODE_FREE;
                    use_mem_next = 1'b0;
                end else if (ev_take) begin
                    got_next = 1'b1;
                    if (is_alloc) begin
                        cst_next   = NODE_ALLOC;
                        total_next = total_reg + blk_size;
                        where_next = off_reg;
                    end else begin
                        cst_next   = NODE_FREE;
                        total_next = total_reg - blk_size;
                    end
                end else begin
                    cst_next = eval_st;
                    got_next = 1'b0;
                end
            end
            S_ASCEND: begin
                if (at_root) begin
                    root_next = cst_reg;
                end else begin
                    ram_we    = 1'b1;
                    ram_waddr = idx_reg;
                    ram_wdata = cst_reg;
                    if (try_right) begin
                        idx_next = idx_reg + NODE_IDX_W'(1);
                        off_next = off_reg + OFF_W'(blk_size);
                    end else begin
                        ram_re    = 1'b1;
                        ram_raddr = sib_idx;
                    end
                end
            end
            S_UP: begin
                cst_next = merge_status(cst_reg, node_st_t'(ram_rdata));
                idx_next = parent_idx;
                lg_next  = lg_reg + LG_W'(1);
                off_next = off_reg & ~OFF_W'(blk_size);
            end
            S_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_ok_next    = got_reg;
                    m_total_next = total_reg;
                    if (is_alloc && got_reg) begin
                        m_addr_next = base_reg + ADDR_W'(where_reg);
                    end else begin
                        m_addr_next = '0;
                    end
                end
            end
            default: begin
            end
        endcase

        // User keeps register writes to idle, unenforced; both empty the pool
        if (cfg_wr_en) begin
            if (cfg_index == REG_BASE_ADDRESS) begin
                base_next  = cfg_wdata;
                root_next  = NODE_FREE;
                total_next = '0;
            end else if (cfg_index == REG_POOL_SIZE_LOG2) begin
                if (cfg_lg > 5'(POOL_LOG2)) begin
                    plog_next = LG_W'(POOL_LOG2);
                end else if (cfg_lg < 5'(MIN_BLOCK_LOG2)) begin
                    plog_next = LG_W'(MIN_BLOCK_LOG2);
                end else begin
                    plog_next = LG_W'(cfg_lg);
                end
                root_next  = NODE_FREE;
                total_next = '0;
            end
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            root_reg    <= NODE_FREE;
            total_reg   <= '0;
            base_reg    <= '0;
            plog_reg    <= LG_W'(POOL_LOG2);
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            root_reg    <= root_next;
            total_reg   <= total_next;
            base_reg    <= base_next;
            plog_reg    <= plog_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Walk and payload registers
    always_ff @(posedge aclk) begin
        idx_reg     <= idx_next;
        lg_reg      <= lg_next;
        off_reg     <= off_next;
        cst_reg     <= cst_next;
        use_mem_reg <= use_mem_next;
        got_reg     <= got_next;
        kind_reg    <= kind_next;
        need_reg    <= need_next;
        addr_reg    <= addr_next;
        where_reg   <= where_next;
        m_addr_reg  <= m_addr_next;
        m_ok_reg    <= m_ok_next;
        m_total_reg <= m_total_next;
    end

    assign s_ready           = state_reg == S_IDLE;
    assign m_valid           = m_valid_reg;
    assign m_block_address   = m_addr_reg;
    assign m_ok              = m_ok_reg;
    assign m_allocated_total = m_total_reg;

    // Checks
    a_no_rw_collision: assert property (@(posedge aclk) disable iff (!aresetn)
        !(ram_we && ram_re && (ram_waddr == ram_raddr)))
        else $error("node memory read and write hit the same entry");

    a_root_level: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_ASCEND) && at_root |-> lg_reg == plog_reg)
        else $error("walk reached the root at the wrong level");

    a_fail_zero_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_ok_reg |-> m_addr_reg == '0)
        else $error("failed request carries a block address");

    a_out_after_reset: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_valid_reg)
        else $error("result valid straight after reset");

endmodule

// ===== rtl/core/bba_node_ram.sv =====
// Node mark memory: one write port, one read port, registered read data.
// Depends on bba_pkg for the tree size.
module bba_node_ram (
    input  logic                          aclk,
    input  logic                          wr_en,
    input  logic [bba_pkg::NODE_IDX_W-1:0] wr_addr,
    input  logic [1:0]                    wr_data,
    input  logic                          rd_en,
    input  logic [bba_pkg::NODE_IDX_W-1:0] rd_addr,
    output logic [1:0]                    rd_data
);
    import bba_pkg::*;

    logic [1:0] mem [NODE_COUNT];
    logic [1:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, registered read data
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sim/bba_checker.sv =====
// Checker for the buddy block allocator: tracks register writes and accepted
// requests, predicts each result and compares it with the result channel.
// Depends on bba_pkg; instantiated beside the block by tb_buddy_block_allocator_top.
module bba_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [bba_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bba_pkg::ADDR_W-1:0]     cfg_wdata,
    input  logic                           s_valid,
    input  logic                           s_ready,
    input  logic                           s_kind,
    input  logic [bba_pkg::SIZE_W-1:0]     s_request_size,
    input  logic [bba_pkg::ADDR_W-1:0]     s_free_address,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  logic [bba_pkg::ADDR_W-1:0]     m_block_address,
    input  logic                           m_ok,
    input  logic [bba_pkg::SIZE_W-1:0]     m_allocated_total,
    output int                             mismatches,
    output int                             outstanding
);
    import bba_pkg::*;

    typedef struct packed {
        logic [ADDR_W-1:0] block_address;
        logic              ok;
        logic [SIZE_W-1:0] allocated_total;
    } grant_t;

    // Model state of the pool
    node_st_t        node_mark [NODE_COUNT];
    logic [63:0]     pool_base;
    int              pool_lg;
    logic [63:0]     bytes_in_use;
    grant_t          grants_due [$];

    // Only the root needs clearing: children are written when a node splits
    function automatic void empty_pool();
        node_mark[0] = NODE_FREE;
        bytes_in_use = 0;
    endfunction

    function automatic logic holds_no_room(node_st_t s);
        return (s == NODE_ALLOC) || (s == NODE_FULL);
    endfunction

    // Recompute a parent mark from its halves
    function automatic void refresh_mark(int i);
        int l;
        l = 2 * i + 1;
        if (l + 1 >= NODE_COUNT) begin
            node_mark[i] = NODE_FREE;
        end else if (holds_no_room(node_mark[l]) && holds_no_room(node_mark[l + 1])) begin
            node_mark[i] = NODE_FULL;
        end else if (node_mark[l] != NODE_FREE || node_mark[l + 1] != NODE_FREE) begin
            node_mark[i] = NODE_SPLIT;
        end else begin
            node_mark[i] = NODE_FREE;
        end
    endfunction

    function automatic void refresh_path(int i);
        while (i > 0) begin
            i = (i - 1) / 2;
            refresh_mark(i);
        end
    endfunction

    // Leftmost-first search for a free leaf big enough, then split it down
    function automatic logic place_block(int need, output logic [63:0] where);
        int          st_idx [64];
        int          st_lg  [64];
        logic [63:0] st_off [64];
        int          sp;
        int          idx;
        int          lg;
        logic [63:0] off;
        logic        found;
        sp = 1;
        st_idx[0] = 0;
        st_lg[0] = pool_lg;
        st_off[0] = 0;
        found = 1'b0;
        where = 0;
        idx = 0;
        lg = 0;
        off = 0;
        while (sp > 0 && !found) begin
            sp = sp - 1;
            idx = st_idx[sp];
            lg = st_lg[sp];
            off = st_off[sp];
            if (idx < NODE_COUNT) begin
                if (node_mark[idx] == NODE_FREE && lg >= need) begin
                    found = 1'b1;
                end else if (node_mark[idx] == NODE_SPLIT && lg > need) begin
                    st_idx[sp] = 2 * idx + 2;
                    st_lg[sp] = lg - 1;
                    st_off[sp] = off + (64'd1 << (lg - 1));
                    st_idx[sp + 1] = 2 * idx + 1;
                    st_lg[sp + 1] = lg - 1;
                    st_off[sp + 1] = off;
                    sp = sp + 2;
                end
            end
        end
        if (!found) begin
            return 1'b0;
        end
        while (lg > need) begin
            node_mark[idx] = NODE_SPLIT;
            node_mark[2 * idx + 1] = NODE_FREE;
            node_mark[2 * idx + 2] = NODE_FREE;
            idx = 2 * idx + 1;
            lg = lg - 1;
        end
        node_mark[idx] = NODE_ALLOC;
        bytes_in_use = bytes_in_use + (64'd1 << need);
        where = off;
        refresh_path(idx);
        return 1'b1;
    endfunction

    // Descend by address and release an allocated leaf starting there
    function automatic logic release_block(logic [63:0] addr);
        int          idx;
        int          lg;
        logic [63:0] off;
        logic        done;
        idx = 0;
        lg = pool_lg;
        off = 0;
        done = 1'b0;
        while ((node_mark[idx] == NODE_SPLIT || node_mark[idx] == NODE_FULL) && lg > 0) begin
            if (pool_base + off + (64'd1 << (lg - 1)) > addr) begin
                idx = 2 * idx + 1;
            end else begin
                off = off + (64'd1 << (lg - 1));
                idx = 2 * idx + 2;
            end
            lg = lg - 1;
        end
        if (node_mark[idx] == NODE_ALLOC && pool_base + off == addr) begin
            node_mark[idx] = NODE_FREE;
            bytes_in_use = bytes_in_use - (64'd1 << lg);
            done = 1'b1;
        end
        refresh_path(idx);
        return done;
    endfunction

    function automatic grant_t predict_grant(logic kind, logic [SIZE_W-1:0] size,
                                             logic [ADDR_W-1:0] addr);
        grant_t      g;
        int          need;
        logic [63:0] where;
        g = '0;
        if (kind == KIND_ALLOC) begin
            need = MIN_BLOCK_LOG2;
            while (need < 63 && (64'd1 << need) < {43'd0, size}) begin
                need++;
            end
            if (need <= pool_lg && place_block(need, where)) begin
                g.ok = 1'b1;
                g.block_address = ADDR_W'(pool_base + where);
            end
        end else begin
            g.ok = release_block({16'd0, addr});
        end
        g.allocated_total = SIZE_W'(bytes_in_use);
        return g;
    endfunction

    function automatic int clamp_lg(logic [4:0] v);
        if (v > POOL_LOG2) return POOL_LOG2;
        if (v < MIN_BLOCK_LOG2) return MIN_BLOCK_LOG2;
        return int'(v);
    endfunction

    // Watch every edge: register writes, results, then new requests
    always @(posedge aclk) begin
        grant_t want;
        if (!aresetn) begin
            pool_base = 0;
            pool_lg = POOL_LOG2;
            empty_pool();
            grants_due.delete();
            mismatches = 0;
        end else begin
            if (cfg_wr_en) begin
                if (cfg_index == REG_BASE_ADDRESS) begin
                    pool_base = {16'd0, cfg_wdata};
                    empty_pool();
                end else if (cfg_index == REG_POOL_SIZE_LOG2) begin
                    pool_lg = clamp_lg(cfg_wdata[4:0]);
                    empty_pool();
                end
            end
            if (m_valid && m_ready) begin
                if (grants_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("checker: unexpected result transfer addr=%h ok=%b total=%0d",
                                 m_block_address, m_ok, m_allocated_total);
                end else begin
                    want = grants_due.pop_front();
                    if (want.block_address !== m_block_address || want.ok !== m_ok ||
                        want.allocated_total !== m_allocated_total) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("checker: mismatch exp addr=%h ok=%b total=%0d, got addr=%h ok=%b total=%0d",
                                     want.block_address, want.ok, want.allocated_total,
                                     m_block_address, m_ok, m_allocated_total);
                    end
                end
            end
            if (s_valid && s_ready)
                grants_due.push_back(predict_grant(s_kind, s_request_size, s_free_address));
        end
        outstanding = grants_due.size();
    end

endmodule

// ===== sim/tb_buddy_block_allocator_top.sv =====
// Testbench top for the buddy block allocator: clock, reset, register phases,
// directed and random requests, result-side back-pressure and the verdict.
// Depends on bba_pkg, buddy_block_allocator_top and bba_checker.
module tb_buddy_block_allocator_top;
    import bba_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000000;
    localparam int RANDOM_ITEMS   = 1000;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [ADDR_W-1:0]     cfg_wdata;
    logic                  s_valid;
    logic                  s_ready;
    logic                  s_kind;
    logic [SIZE_W-1:0]     s_request_size;
    logic [ADDR_W-1:0]     s_free_address;
    logic                  m_valid;
    logic                  m_ready;
    logic [ADDR_W-1:0]     m_block_address;
    logic                  m_ok;
    logic [SIZE_W-1:0]     m_allocated_total;
    int                    mismatches;
    int                    outstanding;

    // Stimulus-side bookkeeping
    logic                  idling_on;
    logic                  hold_req;
    int                    hold_left;
    int                    quiet_cycles;
    int                    items_sent;
    int                    allocs_granted;
    int                    frees_done;
    int                    cur_lg;
    logic                  kinds_sent [$];
    logic [ADDR_W-1:0]     live_blocks [$];

    buddy_block_allocator_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_kind(s_kind),
        .s_request_size(s_request_size), .s_free_address(s_free_address),
        .m_valid(m_valid), .m_ready(m_ready), .m_block_address(m_block_address),
        .m_ok(m_ok), .m_allocated_total(m_allocated_total)
    );

    bba_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_kind(s_kind),
        .s_request_size(s_request_size), .s_free_address(s_free_address),
        .m_valid(m_valid), .m_ready(m_ready), .m_block_address(m_block_address),
        .m_ok(m_ok), .m_allocated_total(m_allocated_total),
        .mismatches(mismatches), .outstanding(outstanding)
    );

    initial aclk = 1'b0;
    always #6 aclk = ~aclk;

    // Receiver: random stalls, plus one long hold-off on request
    initial begin
        m_ready = 1'b0;
        hold_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_req && hold_left == 0) begin
                hold_left = 400;
                hold_req = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (idling_on) begin
                m_ready <= ($urandom_range(99) >= 26);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Track granted blocks so that frees can target live addresses
    always @(posedge aclk) begin
        logic k;
        if (aresetn) begin
            if (m_valid && m_ready && kinds_sent.size() > 0) begin
                k = kinds_sent.pop_front();
                if (k == KIND_ALLOC && m_ok) begin
                    live_blocks.push_back(m_block_address);
                    allocs_granted++;
                end else if (k == KIND_FREE && m_ok) begin
                    frees_done++;
                end
            end
            if (s_valid && s_ready)
                kinds_sent.push_back(s_kind);
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("tb: no transfer for %0d cycles", WATCHDOG_LIMIT);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // Offer one request; valid stays high until the transfer
    task automatic offer_request(logic kind, logic [SIZE_W-1:0] size,
                                 logic [ADDR_W-1:0] addr);
        int gap;
        @(negedge aclk);
        if (idling_on && $urandom_range(99) < 26) begin
            s_valid <= 1'b0;
            gap = $urandom_range(1, 4);
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_kind <= kind;
        s_request_size <= size;
        s_free_address <= addr;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    task automatic drop_valid();
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    // Drain, then write both registers while the block is idle
    task automatic set_pool(logic [ADDR_W-1:0] base, logic [4:0] lg);
        while (outstanding != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_BASE_ADDRESS;
        cfg_wdata <= base;
        @(negedge aclk);
        cfg_index <= REG_POOL_SIZE_LOG2;
        cfg_wdata <= {43'd0, lg};
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        live_blocks.delete();
        cur_lg = (lg > POOL_LOG2) ? POOL_LOG2 : (lg < MIN_BLOCK_LOG2) ? MIN_BLOCK_LOG2 : lg;
    endtask

    // One random request: mostly sizes that fit, frees mostly of live blocks
    task automatic random_request();
        int                pick;
        logic [SIZE_W-1:0] size;
        logic [ADDR_W-1:0] addr;
        if ($urandom_range(99) < 55) begin
            if ($urandom_range(99) < 5)
                size = SIZE_W'($urandom);
            else
                size = SIZE_W'($urandom_range(0, 1 << $urandom_range(0, cur_lg - 1)));
            offer_request(KIND_ALLOC, size, ADDR_W'($urandom));
        end else begin
            if (live_blocks.size() > 0 && $urandom_range(99) < 75) begin
                pick = $urandom_range(0, live_blocks.size() - 1);
                addr = live_blocks[pick];
                live_blocks.delete(pick);
                if ($urandom_range(99) < 10)
                    addr = addr + ADDR_W'($urandom_range(1, 7));
            end else begin
                addr = ADDR_W'({$urandom, $urandom});
            end
            offer_request(KIND_FREE, SIZE_W'($urandom), addr);
        end
    endtask

    initial begin
        logic [ADDR_W-1:0] bases [6];
        logic [4:0]        lgs   [6];
        int                per_phase;
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_valid = 1'b0;
        s_kind = KIND_ALLOC;
        s_request_size = '0;
        s_free_address = '0;
        idling_on = 1'b1;
        hold_req = 1'b0;
        items_sent = 0;
        allocs_granted = 0;
        frees_done = 0;
        cur_lg = POOL_LOG2;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: reset pool, minimum and odd sizes, oversize, merges, bad frees
        offer_request(KIND_ALLOC, 0, '0);
        offer_request(KIND_ALLOC, 1, '1);
        offer_request(KIND_ALLOC, 8, '0);
        offer_request(KIND_ALLOC, 9, '0);
        offer_request(KIND_ALLOC, '1, '0);
        offer_request(KIND_ALLOC, 21'd1048576, '0);
        offer_request(KIND_FREE, '1, 48'd0);
        offer_request(KIND_FREE, 0, 48'd8);
        offer_request(KIND_FREE, 0, 48'd5);
        offer_request(KIND_FREE, 0, '1);
        offer_request(KIND_FREE, 0, 48'd16);
        offer_request(KIND_FREE, 0, 48'd32);
        offer_request(KIND_ALLOC, 21'd1048576, '0);
        offer_request(KIND_ALLOC, 1, '0);
        offer_request(KIND_FREE, 0, 48'd0);
        offer_request(KIND_FREE, 0, 48'd0);
        offer_request(KIND_ALLOC, 21'd1048577, '0);
        drop_valid();

        // Random phases over several pool settings, clamped values among them
        bases[0] = 48'h0;             lgs[0] = 5'd20;
        bases[1] = '1;                lgs[1] = 5'd3;
        bases[2] = 48'h0123_4567_89A8; lgs[2] = 5'd6;
        bases[3] = ADDR_W'({$urandom, $urandom}); lgs[3] = 5'd31;
        bases[4] = 48'hFFFF_FFFF_FF00; lgs[4] = 5'd0;
        bases[5] = 48'h8000_0000_0000; lgs[5] = 5'd10;
        per_phase = RANDOM_ITEMS / 6;
        for (int p = 0; p < 6; p++) begin
            set_pool(bases[p], lgs[p]);
            for (int i = 0; i < per_phase; i++) begin
                if (p == 0 && i == 40) hold_req = 1'b1;
                idling_on = !(p == 3 && i >= 30 && i < 130);
                random_request();
            end
            drop_valid();
        end
        idling_on = 1'b1;

        // Drain and let the block settle
        while (outstanding != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        $display("tb: %0d requests over 7 pool settings, %0d allocations granted, %0d blocks freed",
                 items_sent, allocs_granted, frees_done);
        $display("tb: includes oversize, zero-size, unknown-address frees and a long result stall");
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("tb: %0d mismatches", mismatches);
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
